[sv/dda_pkg.sv]
// Shared constants and control types for the DDA line rasterizer.
package dda_pkg;

	// Default build values
	localparam int COORD_SPAN_DEF = 64;
	localparam int FRAC_BITS_DEF  = 8;

	// Fixed field widths
	localparam int COORD_IN_W = 14;
	localparam int PIX_W      = 7;
	localparam int ADDR_W     = 13;
	localparam int CFG_W      = 7;
	localparam int CFG_IDX_W  = 1;

	// Step fraction and divider length (one integer bit plus the fraction bits)
	localparam int STEP_FRAC = 16;
	localparam int DIV_STEPS = STEP_FRAC + 1;
	localparam int QUO_W     = STEP_FRAC + 1;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_HEIGHT = 1'd1;

	// Register reset values
	localparam logic [CFG_W-1:0] CANVAS_WIDTH_RST  = 7'd40;
	localparam logic [CFG_W-1:0] CANVAS_HEIGHT_RST = 7'd20;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;       // capture a line beat
		logic setup;      // form deltas, step count, start the divider
		logic step_load;  // latch the signed per-axis steps
		logic emit;       // write one point to the output register and advance
	} dda_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic div_done;   // both quotients are ready
		logic last;       // the next point is the final one of the line
	} dda_stat_t;

endpackage

[sv/dda_div.sv]
// Two-lane serial restoring divider: quotient = (num << 16) / den, one bit per cycle.
module dda_div #(
	parameter int CW = 14
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [CW-1:0]            num_x,
	input  logic [CW-1:0]            num_y,
	input  logic [CW-1:0]            den,
	output logic                     done,
	output logic [dda_pkg::QUO_W-1:0] quo_x,
	output logic [dda_pkg::QUO_W-1:0] quo_y
);
	import dda_pkg::*;

	localparam int CNT_W = $clog2(DIV_STEPS);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CW-1:0]    den_q;
	logic [CW-1:0]    rem_x_q;
	logic [CW-1:0]    rem_y_q;
	logic [QUO_W-1:0] quo_x_q;
	logic [QUO_W-1:0] quo_y_q;

	logic [CW:0] shx;
	logic [CW:0] shy;
	logic [CW:0] subx;
	logic [CW:0] suby;
	logic        gex;
	logic        gey;

	// The first bit compares the unshifted numerator; later bits shift the remainder
	always_comb begin
		if (cnt_q == '0) begin
			shx = {1'b0, rem_x_q};
			shy = {1'b0, rem_y_q};
		end else begin
			shx = {rem_x_q, 1'b0};
			shy = {rem_y_q, 1'b0};
		end
		gex  = shx >= {1'b0, den_q};
		gey  = shy >= {1'b0, den_q};
		subx = shx - {1'b0, den_q};
		suby = shy - {1'b0, den_q};
	end

	// Sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	// Remainders and quotient bits
	always_ff @(posedge clk) begin
		if (start) begin
			den_q   <= den;
			rem_x_q <= num_x;
			rem_y_q <= num_y;
			quo_x_q <= '0;
			quo_y_q <= '0;
		end else if (busy_q) begin
			rem_x_q <= gex ? subx[CW-1:0] : shx[CW-1:0];
			rem_y_q <= gey ? suby[CW-1:0] : shy[CW-1:0];
			quo_x_q <= {quo_x_q[QUO_W-2:0], gex};
			quo_y_q <= {quo_y_q[QUO_W-2:0], gey};
		end
	end

	assign done  = done_q;
	assign quo_x = quo_x_q;
	assign quo_y = quo_y_q;

endmodule

[sv/dda_dp.sv]
// Datapath: canvas registers, line setup, step divider, position accumulators, point output.
module dda_dp #(
	parameter int COORD_SPAN = dda_pkg::COORD_SPAN_DEF,
	parameter int FRAC_BITS  = dda_pkg::FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  dda_pkg::dda_cmd_t               cmd,
	output dda_pkg::dda_stat_t              stat,
	input  logic                            cfg_we,
	input  logic [dda_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [dda_pkg::CFG_W-1:0]       cfg_data,
	input  logic [dda_pkg::COORD_IN_W-1:0]  start_x,
	input  logic [dda_pkg::COORD_IN_W-1:0]  start_y,
	input  logic [dda_pkg::COORD_IN_W-1:0]  end_x,
	input  logic [dda_pkg::COORD_IN_W-1:0]  end_y,
	output logic [dda_pkg::PIX_W-1:0]       pixel_x,
	output logic [dda_pkg::PIX_W-1:0]       pixel_y,
	output logic                            on_canvas,
	output logic [dda_pkg::ADDR_W-1:0]      pixel_address,
	output logic                            last_point
);
	import dda_pkg::*;

	// Coordinate, count, position and rounding widths
	localparam int CW   = $clog2(COORD_SPAN << FRAC_BITS);
	localparam int RW   = CW - FRAC_BITS;
	localparam int PW   = CW + STEP_FRAC - FRAC_BITS;
	localparam int IW   = (CW > COORD_IN_W) ? CW : COORD_IN_W;
	localparam int RXW  = (PW + 1 > STEP_FRAC + PIX_W) ? PW + 1 : STEP_FRAC + PIX_W;
	localparam logic [IW-1:0]  COORD_MASK = IW'((COORD_SPAN << FRAC_BITS) - 1);
	localparam logic [RXW-1:0] HALF       = RXW'(1) << (STEP_FRAC - 1);
	localparam int PROD_W = 2 * PIX_W + 1;

	function automatic logic [CW-1:0] mask_coord(input logic [COORD_IN_W-1:0] c);
		logic [IW-1:0] ext;
		ext = IW'(c) & COORD_MASK;
		return ext[CW-1:0];
	endfunction

	logic [CFG_W-1:0] width_q;
	logic [CFG_W-1:0] height_q;

	logic [CW-1:0] sx_q;
	logic [CW-1:0] sy_q;
	logic [CW-1:0] ex_q;
	logic [CW-1:0] ey_q;

	logic          neg_x_q;
	logic          neg_y_q;
	logic          zero_q;
	logic [RW-1:0] remain_q;
	logic [PW-1:0] pos_x_q;
	logic [PW-1:0] pos_y_q;
	logic [PW-1:0] step_x_q;
	logic [PW-1:0] step_y_q;

	logic [PIX_W-1:0]  pixel_x_q;
	logic [PIX_W-1:0]  pixel_y_q;
	logic              on_canvas_q;
	logic [ADDR_W-1:0] pixel_address_q;
	logic              last_point_q;

	logic [CW:0]   dx;
	logic [CW:0]   dy;
	logic [CW-1:0] adx;
	logic [CW-1:0] ady;
	logic [CW-1:0] dmax;

	logic              div_done;
	logic [QUO_W-1:0]  quo_x;
	logic [QUO_W-1:0]  quo_y;

	logic [RXW-1:0]    rnd_x;
	logic [RXW-1:0]    rnd_y;
	logic [PIX_W-1:0]  pix_x;
	logic [PIX_W-1:0]  pix_y;
	logic              on_cv;
	logic [PIX_W-1:0]  row;
	logic [PIX_W:0]    pitch;
	logic [PROD_W-1:0] addr_full;

	// Canvas registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CANVAS_WIDTH_RST;
			height_q <= CANVAS_HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CANVAS_WIDTH:  width_q  <= cfg_data;
				CFG_CANVAS_HEIGHT: height_q <= cfg_data;
			endcase
		end
	end

	// Deltas, magnitudes and the major-axis length
	always_comb begin
		dx   = {1'b0, ex_q} - {1'b0, sx_q};
		dy   = {1'b0, ey_q} - {1'b0, sy_q};
		adx  = dx[CW] ? CW'(-dx) : dx[CW-1:0];
		ady  = dy[CW] ? CW'(-dy) : dy[CW-1:0];
		dmax = (adx > ady) ? adx : ady;
	end

	dda_div #(
		.CW (CW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.setup),
		.num_x  (adx),
		.num_y  (ady),
		.den    (dmax),
		.done   (div_done),
		.quo_x  (quo_x),
		.quo_y  (quo_y)
	);

	// Round half up and place on the canvas
	always_comb begin
		rnd_x     = RXW'(pos_x_q) + HALF;
		rnd_y     = RXW'(pos_y_q) + HALF;
		pix_x     = rnd_x[STEP_FRAC +: PIX_W];
		pix_y     = rnd_y[STEP_FRAC +: PIX_W];
		on_cv     = (pix_x < width_q) && (pix_y < height_q);
		row       = height_q - pix_y - PIX_W'(1);
		pitch     = {1'b0, width_q} + (PIX_W + 1)'(1);
		addr_full = PROD_W'(row) * PROD_W'(pitch) + PROD_W'(pix_x);
	end

	// Line capture, setup, step latch and point walk
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sx_q <= mask_coord(start_x);
			sy_q <= mask_coord(start_y);
			ex_q <= mask_coord(end_x);
			ey_q <= mask_coord(end_y);
		end
		if (cmd.setup) begin
			neg_x_q  <= dx[CW];
			neg_y_q  <= dy[CW];
			zero_q   <= (dmax == '0);
			remain_q <= dmax[CW-1:FRAC_BITS];
			pos_x_q  <= {sx_q, (STEP_FRAC - FRAC_BITS)'(0)};
			pos_y_q  <= {sy_q, (STEP_FRAC - FRAC_BITS)'(0)};
		end
		if (cmd.step_load) begin
			if (zero_q) begin
				step_x_q <= '0;
				step_y_q <= '0;
			end else begin
				step_x_q <= neg_x_q ? -PW'(quo_x) : PW'(quo_x);
				step_y_q <= neg_y_q ? -PW'(quo_y) : PW'(quo_y);
			end
		end
		if (cmd.emit) begin
			pixel_x_q       <= pix_x;
			pixel_y_q       <= pix_y;
			on_canvas_q     <= on_cv;
			pixel_address_q <= on_cv ? addr_full[ADDR_W-1:0] : '0;
			last_point_q    <= (remain_q == '0);
			pos_x_q         <= pos_x_q + step_x_q;
			pos_y_q         <= pos_y_q + step_y_q;
			remain_q        <= remain_q - 1'b1;
		end
	end

	assign stat.div_done = div_done;
	assign stat.last     = (remain_q == '0);

	assign pixel_x       = pixel_x_q;
	assign pixel_y       = pixel_y_q;
	assign on_canvas     = on_canvas_q;
	assign pixel_address = pixel_address_q;
	assign last_point    = last_point_q;

endmodule

[sv/dda_ctrl.sv]
// Controller: line sequencing state machine and the output valid flag.
module dda_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                line_valid,
	output logic                line_stall,
	output logic                point_valid,
	input  logic                point_stall,
	output dda_pkg::dda_cmd_t   cmd,
	input  dda_pkg::dda_stat_t  stat
);
	import dda_pkg::*;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SETUP = 2'd1;
	localparam logic [1:0] S_DIV   = 2'd2;
	localparam logic [1:0] S_EMIT  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nx;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || !point_stall;

	// Next state and commands
	always_comb begin
		state_nx      = state_q;
		cmd           = '0;
		line_stall    = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				line_stall = 1'b0;
				if (line_valid) begin
					cmd.load = 1'b1;
					state_nx = S_SETUP;
				end
			end
			S_SETUP: begin
				cmd.setup = 1'b1;
				state_nx  = S_DIV;
			end
			S_DIV: begin
				if (stat.div_done) begin
					cmd.step_load = 1'b1;
					state_nx      = S_EMIT;
				end
			end
			S_EMIT: begin
				if (out_free) begin
					cmd.emit = 1'b1;
					if (stat.last) begin
						state_nx = S_IDLE;
					end
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	// State and output valid; hold a point while the sink stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!point_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign point_valid = out_valid_q;

endmodule

[sv/dda_line_rasterizer.sv]
// Top level of the DDA line rasterizer: line in, one point beat per step out.
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+-----------------------------------------
//   line     | line_valid / line_stall     | start_x, start_y, end_x, end_y
//   point    | point_valid / point_stall   | pixel_x, pixel_y, on_canvas,
//            |                             | pixel_address, last_point
//   cfg      | cfg_valid / cfg_ready       | cfg_index, cfg_data
//
// A line of N = floor(max(|dx|,|dy|)) + 1 points passes through an accept state, a setup state,
// the serial step divider (one quotient bit per cycle for both axes) and a step latch,
// then gives one point per cycle while point_stall is low.
// Reset loads the canvas registers (width 40, height 20); no clearing pass is needed.
// A point waits in the output register while point_stall is high, and the walk halts;
// the next line is taken once the last point of the current one sits in that register.
module dda_line_rasterizer #(
	parameter int COORD_SPAN = dda_pkg::COORD_SPAN_DEF,
	parameter int FRAC_BITS  = dda_pkg::FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [dda_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [dda_pkg::CFG_W-1:0]       cfg_data,
	input  logic                            line_valid,
	output logic                            line_stall,
	input  logic [dda_pkg::COORD_IN_W-1:0]  start_x,
	input  logic [dda_pkg::COORD_IN_W-1:0]  start_y,
	input  logic [dda_pkg::COORD_IN_W-1:0]  end_x,
	input  logic [dda_pkg::COORD_IN_W-1:0]  end_y,
	output logic                            point_valid,
	input  logic                            point_stall,
	output logic [dda_pkg::PIX_W-1:0]       pixel_x,
	output logic [dda_pkg::PIX_W-1:0]       pixel_y,
	output logic                            on_canvas,
	output logic [dda_pkg::ADDR_W-1:0]      pixel_address,
	output logic                            last_point
);
	import dda_pkg::*;

	dda_cmd_t  cmd;
	dda_stat_t stat;

	// Registers take a write in any cycle
	assign cfg_ready = 1'b1;

	dda_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.line_valid  (line_valid),
		.line_stall  (line_stall),
		.point_valid (point_valid),
		.point_stall (point_stall),
		.cmd         (cmd),
		.stat        (stat)
	);

	dda_dp #(
		.COORD_SPAN (COORD_SPAN),
		.FRAC_BITS  (FRAC_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.start_x       (start_x),
		.start_y       (start_y),
		.end_x         (end_x),
		.end_y         (end_y),
		.pixel_x       (pixel_x),
		.pixel_y       (pixel_y),
		.on_canvas     (on_canvas),
		.pixel_address (pixel_address),
		.last_point    (last_point)
	);

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the DDA line rasterizer: directed and random lines, canvas settings, stalls.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import dda_pkg::*;

	localparam longint COORD_MASK    = (longint'(COORD_SPAN_DEF) << FRAC_BITS_DEF) - 1;
	localparam int     COORD_MAX     = (COORD_SPAN_DEF << FRAC_BITS_DEF) - 1;
	localparam int     LONG_GAP_MAX  = 40;
	localparam int     SETTLE_CYCLES = 4;
	localparam int     TAIL_CYCLES   = 90;
	localparam int     PHASES        = 8;
	localparam int     CHUNK         = 30;
	localparam int     CYCLE_LIMIT   =
		3 * 520 * (64 * (LONG_GAP_MAX + 1) + LONG_GAP_MAX + 24) + 20000;

	typedef struct packed {
		logic [COORD_IN_W-1:0] sx;
		logic [COORD_IN_W-1:0] sy;
		logic [COORD_IN_W-1:0] ex;
		logic [COORD_IN_W-1:0] ey;
	} line_t;

	typedef struct packed {
		logic [PIX_W-1:0]  x;
		logic [PIX_W-1:0]  y;
		logic              on;
		logic [ADDR_W-1:0] addr;
		logic              last;
	} point_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_CANVAS_WIDTH;
	logic [CFG_W-1:0]      cfg_data = '0;
	logic                  line_valid = 1'b0;
	logic                  line_stall;
	logic [COORD_IN_W-1:0] start_x = '0;
	logic [COORD_IN_W-1:0] start_y = '0;
	logic [COORD_IN_W-1:0] end_x = '0;
	logic [COORD_IN_W-1:0] end_y = '0;
	logic                  point_valid;
	logic                  point_stall = 1'b0;
	logic [PIX_W-1:0]      pixel_x;
	logic [PIX_W-1:0]      pixel_y;
	logic                  on_canvas;
	logic [ADDR_W-1:0]     pixel_address;
	logic                  last_point;

	// Canvas registers as the block should hold them
	logic [CFG_W-1:0] canvas_w = CANVAS_WIDTH_RST;
	logic [CFG_W-1:0] canvas_h = CANVAS_HEIGHT_RST;

	line_t  pending_lines[$];
	point_t expected_points[$];

	logic line_taken = 1'b0;
	bit   calm_tx = 1'b0;
	bit   calm_rx = 1'b0;
	int   send_gap = 0;
	int   stall_left = 0;
	int   error_count = 0;
	int   lines_sent = 0;
	int   points_checked = 0;
	int   settings_used = 1;
	int   cycle_count = 0;

	dda_line_rasterizer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.line_valid    (line_valid),
		.line_stall    (line_stall),
		.start_x       (start_x),
		.start_y       (start_y),
		.end_x         (end_x),
		.end_y         (end_y),
		.point_valid   (point_valid),
		.point_stall   (point_stall),
		.pixel_x       (pixel_x),
		.pixel_y       (pixel_y),
		.on_canvas     (on_canvas),
		.pixel_address (pixel_address),
		.last_point    (last_point)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Idle length: mostly none, some short, a few long
	function automatic int pick_gap(input bit calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, LONG_GAP_MAX);
	endfunction

	function automatic int clamp_coord(input int v);
		return v < 0 ? 0 : (v > COORD_MAX ? COORD_MAX : v);
	endfunction

	// Mix of short, axis-aligned, zero-length, corner-to-corner and free lines
	function automatic line_t random_line();
		line_t l;
		int kind, reach, x0, y0, x1, y1;
		kind = $urandom_range(0, 99);
		x0 = $urandom_range(0, COORD_MAX);
		y0 = $urandom_range(0, COORD_MAX);
		x1 = $urandom_range(0, COORD_MAX);
		y1 = $urandom_range(0, COORD_MAX);
		if (kind < 45) begin
			reach = $urandom_range(0, 2048);
			x1 = clamp_coord(x0 + int'($urandom_range(0, 2 * reach)) - reach);
			y1 = clamp_coord(y0 + int'($urandom_range(0, 2 * reach)) - reach);
		end else if (kind < 58) begin
			if ($urandom_range(0, 1))
				y1 = y0;
			else
				x1 = x0;
		end else if (kind < 66) begin
			x1 = x0;
			y1 = y0;
		end else if (kind < 74) begin
			x0 = $urandom_range(0, 1) ? COORD_MAX : 0;
			y0 = $urandom_range(0, 1) ? COORD_MAX : 0;
			x1 = $urandom_range(0, 1) ? COORD_MAX : 0;
			y1 = $urandom_range(0, 1) ? COORD_MAX : 0;
		end
		// Park the start on a half-pixel boundary now and then
		if ($urandom_range(0, 4) == 0) begin
			x0 = (x0 & ~255) | ($urandom_range(0, 1) ? 'h80 : 'h7F);
			y0 = (y0 & ~255) | ($urandom_range(0, 1) ? 'h80 : 'h7F);
		end
		l.sx = COORD_IN_W'(x0);
		l.sy = COORD_IN_W'(y0);
		l.ex = COORD_IN_W'(x1);
		l.ey = COORD_IN_W'(y1);
		return l;
	endfunction

	// Walk one line and queue every point it should produce
	function automatic void plot_line(input line_t l);
		longint sx, sy, dx, dy, adx, ady, dmax, stx, sty, px, py, ix, iy, addr;
		int count;
		bit on;
		point_t pt;
		sx = l.sx & COORD_MASK;
		sy = l.sy & COORD_MASK;
		dx = (l.ex & COORD_MASK) - sx;
		dy = (l.ey & COORD_MASK) - sy;
		adx = dx < 0 ? -dx : dx;
		ady = dy < 0 ? -dy : dy;
		dmax = adx > ady ? adx : ady;
		// Zero-length line: no division, both steps stay zero
		stx = dmax == 0 ? 0 : (adx << STEP_FRAC) / dmax;
		sty = dmax == 0 ? 0 : (ady << STEP_FRAC) / dmax;
		if (dx < 0)
			stx = -stx;
		if (dy < 0)
			sty = -sty;
		px = sx * (longint'(1) << (STEP_FRAC - FRAC_BITS_DEF));
		py = sy * (longint'(1) << (STEP_FRAC - FRAC_BITS_DEF));
		count = int'(dmax >> FRAC_BITS_DEF) + 1;
		for (int k = 0; k < count; k++) begin
			ix = (((px < 0 ? 0 : px) + (longint'(1) << (STEP_FRAC - 1))) >> STEP_FRAC) & 'h7F;
			iy = (((py < 0 ? 0 : py) + (longint'(1) << (STEP_FRAC - 1))) >> STEP_FRAC) & 'h7F;
			on = ix < longint'(canvas_w) && iy < longint'(canvas_h);
			addr = 0;
			if (on)
				addr = ((longint'(canvas_h) - iy - 1) * (longint'(canvas_w) + 1) + ix) & 'h1FFF;
			pt.x = ix[PIX_W-1:0];
			pt.y = iy[PIX_W-1:0];
			pt.on = on;
			pt.addr = addr[ADDR_W-1:0];
			pt.last = (k == count - 1);
			expected_points.push_back(pt);
			px += stx;
			py += sty;
		end
	endfunction

	task automatic compare_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			error_count++;
		end
	endtask

	// Line driver: hold a stalled beat, otherwise idle or present the next line
	always @(negedge clk) begin
		if (arst_n) begin
			if (line_valid && !line_taken) begin
				// hold
			end else if (send_gap > 0) begin
				line_valid <= 1'b0;
				send_gap = send_gap - 1;
			end else if (pending_lines.size() != 0) begin
				line_t l;
				l = pending_lines.pop_front();
				start_x <= l.sx;
				start_y <= l.sy;
				end_x <= l.ex;
				end_y <= l.ey;
				line_valid <= 1'b1;
				if ($urandom_range(0, 49) == 0)
					calm_tx = !calm_tx;
				send_gap = pick_gap(calm_tx);
			end else begin
				line_valid <= 1'b0;
			end
		end
	end

	// Point receiver stall pattern
	always @(negedge clk) begin
		if (stall_left > 0) begin
			point_stall <= 1'b1;
			stall_left = stall_left - 1;
		end else begin
			point_stall <= 1'b0;
			if ($urandom_range(0, 3) == 0)
				stall_left = pick_gap(calm_rx);
		end
		if ($urandom_range(0, 199) == 0)
			calm_rx = !calm_rx;
	end

	// Monitor: predict on each accepted line beat, check each accepted point beat
	always @(posedge clk) begin
		point_t want;
		if (arst_n) begin
			line_taken <= line_valid && !line_stall;
			if (line_valid && !line_stall) begin
				plot_line('{start_x, start_y, end_x, end_y});
				lines_sent++;
			end
			if (point_valid && !point_stall) begin
				if (expected_points.size() == 0) begin
					$error("point beat with no line pending: x=%0d y=%0d", pixel_x, pixel_y);
					error_count++;
				end else begin
					want = expected_points.pop_front();
					compare_field("pixel_x", 16'(want.x), 16'(pixel_x));
					compare_field("pixel_y", 16'(want.y), 16'(pixel_y));
					compare_field("on_canvas", 16'(want.on), 16'(on_canvas));
					compare_field("pixel_address", 16'(want.addr), 16'(pixel_address));
					compare_field("last_point", 16'(want.last), 16'(last_point));
					points_checked++;
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count = cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d points still owed",
				cycle_count, expected_points.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_CANVAS_WIDTH)
			canvas_w = val;
		else
			canvas_h = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Wait until every queued line is sent and every point has come back
	task automatic wait_idle();
		do @(posedge clk);
		while (pending_lines.size() != 0 || line_valid || expected_points.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int w, h;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed lines at the reset canvas of 40 x 20
		pending_lines.push_back(line_t'{0, 0, 0, 0});
		pending_lines.push_back(line_t'{COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX});
		pending_lines.push_back(line_t'{'h80, 'h7F, 'h80, 'h7F});
		pending_lines.push_back(line_t'{0, 0, COORD_MAX, 0});
		pending_lines.push_back(line_t'{0, 0, 0, COORD_MAX});
		pending_lines.push_back(line_t'{COORD_MAX, COORD_MAX, 0, 0});
		pending_lines.push_back(line_t'{0, COORD_MAX, COORD_MAX, 0});
		pending_lines.push_back(line_t'{1000, 200, 300, 5000});
		pending_lines.push_back(line_t'{5000, 100, 300, 900});
		pending_lines.push_back(line_t'{'h3FFF, 0, 'h2AAA, 'h1555});
		pending_lines.push_back(line_t'{'h1555, 'h2AAA, 'h2AAA, 'h1555});
		pending_lines.push_back(line_t'{100, 100, 356, 100});
		pending_lines.push_back(line_t'{100, 100, 355, 100});
		pending_lines.push_back(line_t'{10 * 256, 19 * 256, 39 * 256, 0});
		pending_lines.push_back(line_t'{40 * 256, 20 * 256, 40 * 256, 20 * 256});
		pending_lines.push_back(line_t'{39 * 256 + 127, 0, 39 * 256 + 128, 19 * 256 + 128});
		pending_lines.push_back(line_t'{200, 16000, 9000, 16100});
		wait_idle();

		// Random lines over a run of canvas settings, extremes first
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin w = 64;  h = 64;  end
				1: begin w = 1;   h = 1;   end
				2: begin w = 0;   h = 20;  end
				3: begin w = 40;  h = 0;   end
				4: begin w = 127; h = 127; end
				5: begin w = 64;  h = 1;   end
				default: begin
					w = $urandom_range(1, 64);
					h = $urandom_range(1, 64);
				end
			endcase
			write_reg(CFG_CANVAS_WIDTH, CFG_W'(w));
			write_reg(CFG_CANVAS_HEIGHT, CFG_W'(h));
			settings_used++;
			// Pause the sender between halves until all points are back
			repeat (2) begin
				repeat (CHUNK) pending_lines.push_back(random_line());
				wait_idle();
			end
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Sent %0d lines and checked %0d points across %0d canvas settings,",
			lines_sent, points_checked, settings_used);
		$display("including zero-length, reversed, full-span and off-canvas lines.");
		if (error_count == 0 && expected_points.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

[sim.f]
sv/dda_pkg.sv
sv/dda_div.sv
sv/dda_dp.sv
sv/dda_ctrl.sv
sv/dda_line_rasterizer.sv
tb/tb_top.sv
